// ----- hdl/pairwise_aabb_collision_engine_unit_macros.svh -----
// Assertion macros for the collision engine checker.
// No dependencies; included by the checker file only.
`ifndef PAIRWISE_AABB_COLLISION_ENGINE_UNIT_MACROS_SVH
`define PAIRWISE_AABB_COLLISION_ENGINE_UNIT_MACROS_SVH
// implication checked every clock, idle in reset
`define PAC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PAC_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hdl/pac_pkg.sv -----
// Package for the pairwise box collision engine.
// Holds sizes, the body record type and the overlap helper; no dependencies.
package pac_pkg;
  localparam int MAX_BODIES = 64;
  localparam int COORD_BITS = 32;
  localparam int IDX_BITS = $clog2(MAX_BODIES);
  localparam int CNT_BITS = $clog2(MAX_BODIES + 1);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0] ovl_t;

  typedef struct packed {
    logic [15:0] id;
    logic        is_static;
    logic        is_flat;
    coord_t      mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
  } body_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] id_b;
    logic [1:0]  axis;
    logic        neg;
    coord_t      b_x, b_y, b_z;
  } cmp_t;

  // overlap length on one axis, one bit wider so it never wraps
  function automatic ovl_t ovl(coord_t amn, coord_t amx, coord_t bmn, coord_t bmx);
    coord_t l, h;
    l = (amx < bmx) ? amx : bmx;
    h = (amn > bmn) ? amn : bmn;
    return ovl_t'(l) - ovl_t'(h);
  endfunction
endpackage

// ----- hdl/pairwise_aabb_collision_engine_unit.sv -----
// Pairwise box collision engine, top level.
// Depends on pac_pkg, pac_cell, pac_compare.
//
// Usage: drive a body on the input ports with start high while busy is low.
// The body is tested against every body stored earlier in the frame; the
// store is a chain of cells that rotates one place per cycle, so the head
// cell meets the compare unit once per stored body. Each hit (overlapping
// boxes, not both static, same flat flag) gives a result beat, strobed by
// valid for one cycle; last_hit marks the final one. busy stays high while
// the stored bodies are compared and the held hit is flushed, and no new
// body is accepted until it falls. One hit is held back so the final one
// can be flagged: a beat shows once the next hit is found, and the last
// beat shows in the first cycle in which busy is low again. An item that
// is skipped (disabled, inactive, full store) is not stored, busy stays low.
// The receiver cannot stall: every beat is taken in the cycle it shows.
// cfg_we/cfg_data write the enabled bit at any edge; write only when idle.
// frame_start, taken with an accepted start, empties the store even when disabled.
// Reset (rst, synchronous) empties the store and clears enabled; stored
// entries are not cleared, only the count.
module pairwise_aabb_collision_engine_unit import pac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        frame_start,
  input  logic [15:0] entity_id,
  input  logic        is_active,
  input  logic        is_static,
  input  logic        is_flat,
  input  coord_t      min_x, min_y, min_z, max_x, max_y, max_z,
  output logic        valid,
  output logic [15:0] body_a,
  output logic [15:0] body_b,
  output logic [1:0]  normal_axis,
  output logic        normal_a_negative,
  output coord_t      contact_a_x, contact_a_y, contact_a_z,
  output coord_t      contact_b_x, contact_b_y, contact_b_z,
  output logic        last_hit
);
  logic enabled;
  logic [CNT_BITS-1:0] count, left;
  logic scan, load;
  logic cmp_v, cmp_last;
  logic pend, flush;
  body_t a;
  body_t chain [MAX_BODIES];
  cmp_t cres, held;
  logic [CNT_BITS-1:0] cnt_eff;

  assign cnt_eff = frame_start ? '0 : count;
  assign busy = scan || cmp_v || flush;

  // config and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      count <= '0;
      scan <= 1'b0;
      load <= 1'b0;
      cmp_v <= 1'b0;
      left <= '0;
    end else begin
      if (cfg_we) enabled <= cfg_data;
      load <= 1'b0;
      cmp_v <= scan && (left != '0);
      cmp_last <= scan && (left == CNT_BITS'(1));
      if (start && !busy) begin
        count <= cnt_eff;
        if (enabled && is_active && cnt_eff < CNT_BITS'(MAX_BODIES)) begin
          scan <= 1'b1;
          left <= cnt_eff;
        end
      end else if (scan) begin
        if (left == '0) begin
          scan <= 1'b0;
          load <= 1'b1;
          count <= count + CNT_BITS'(1);
        end else begin
          left <= left - CNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a <= '{entity_id, is_static, is_flat, min_x, min_y, min_z, max_x, max_y, max_z};
    end
  end

  // chain: entries 0..count-1; rotate within the used part, new body lands
  // in the slot below count, which was already bumped when load was raised
  genvar g;
  for (g = 0; g < MAX_BODIES; g++) begin : g_cell
    logic sh;
    assign sh = scan && (left != '0) && (IDX_BITS'(g) < count[IDX_BITS-1:0] ||
                count == CNT_BITS'(MAX_BODIES));
    pac_cell u_cell (
      .clk(clk),
      .load(load && (count[IDX_BITS-1:0] - IDX_BITS'(1)) == IDX_BITS'(g)),
      .shift(sh),
      .new_body(a),
      .prev_body((IDX_BITS'(g) == count[IDX_BITS-1:0] - IDX_BITS'(1)) ? chain[0]
                 : chain[(g + 1) % MAX_BODIES]),
      .body(chain[g])
    );
  end

  pac_compare u_cmp (
    .clk(clk),
    .en(scan && (left != '0)),
    .a(a),
    .b(chain[0]),
    .res(cres)
  );

  // hold one hit back so the last one can be flagged; flush is raised in the
  // cycle after the last compare result and sends the held hit as the final beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      flush <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      flush <= cmp_v && cmp_last;
      if (cmp_v && cres.hit) begin
        held <= cres;
        pend <= 1'b1;
      end else if (flush) begin
        pend <= 1'b0;
      end
      if (pend && ((cmp_v && cres.hit) || flush)) begin
        valid <= 1'b1;
        last_hit <= flush;
        body_b <= held.id_b;
        normal_axis <= held.axis;
        normal_a_negative <= held.neg;
        contact_b_x <= held.b_x; contact_b_y <= held.b_y; contact_b_z <= held.b_z;
        body_a <= a.id;
        contact_a_x <= a.mn_x;
        contact_a_y <= a.mn_y;
        contact_a_z <= a.is_flat ? '0 : a.mn_z;
      end
    end
  end
endmodule

// ----- hdl/pac_cell.sv -----
// One storage cell of the body chain: holds a stored body and shifts it on.
// Depends on pac_pkg.
module pac_cell import pac_pkg::*; (
  input  logic  clk,
  input  logic  load,
  input  logic  shift,
  input  body_t new_body,
  input  body_t prev_body,
  output body_t body
);
  // load takes the new body at the tail, shift rotates the chain
  always_ff @(posedge clk) begin
    if (load) begin
      body <= new_body;
    end else if (shift) begin
      body <= prev_body;
    end
  end
endmodule

// ----- hdl/pac_compare.sv -----
// Registered pair test of the incoming body against one stored body.
// Depends on pac_pkg.
module pac_compare import pac_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  body_t a,
  input  body_t b,
  output cmp_t  res
);
  cmp_t  c;
  ovl_t  ox, oy, oz;
  logic  apart;
  coord_t amx, bmx;

  always_comb begin
    ox = ovl(a.mn_x, a.mx_x, b.mn_x, b.mx_x);
    oy = ovl(a.mn_y, a.mx_y, b.mn_y, b.mx_y);
    oz = ovl(a.mn_z, a.mx_z, b.mn_z, b.mx_z);
    apart = (a.mx_x < b.mn_x) || (a.mn_x > b.mx_x) ||
            (a.mx_y < b.mn_y) || (a.mn_y > b.mx_y) ||
            (!a.is_flat && ((a.mx_z < b.mn_z) || (a.mn_z > b.mx_z)));
    c.hit = en && !(a.is_static && b.is_static) && (a.is_flat == b.is_flat) && !apart;
    c.id_b = b.id;
    // least overlap, but any tie for the least goes to Z (to Y for flat bodies), even when Z overlaps more
    if (a.is_flat) begin
      c.axis = (ox < oy) ? AXIS_X : AXIS_Y;
    end else if (ox < oy && ox < oz) begin
      c.axis = AXIS_X;
    end else if (oy < ox && oy < oz) begin
      c.axis = AXIS_Y;
    end else begin
      c.axis = AXIS_Z;
    end
    case (c.axis)
      AXIS_X: begin amx = a.mx_x; bmx = b.mx_x; end
      AXIS_Y: begin amx = a.mx_y; bmx = b.mx_y; end
      default: begin amx = a.mx_z; bmx = b.mx_z; end
    endcase
    c.neg = amx < bmx;
    c.b_x = b.mn_x;
    c.b_y = b.mn_y;
    c.b_z = a.is_flat ? '0 : b.mn_z;
  end

  always_ff @(posedge clk) begin
    res <= c;
  end
endmodule

// ----- hdl/pac_checker.sv -----
// Port-level checker for the collision engine, bound to the top level.
// Depends on the macros header.
`include "pairwise_aabb_collision_engine_unit_macros.svh"
module pac_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid,
  input logic last_hit,
  input logic [1:0] normal_axis
);
  `PAC_ASSERT_IMP(a_axis_ok, clk, rst, valid, normal_axis != 2'd3)
  `PAC_ASSERT_IMP(a_valid_busy, clk, rst, valid && !last_hit, busy)
  `PAC_ASSERT_NXT(a_last_ends, clk, rst, valid && last_hit, !valid)
  // nothing of an earlier item shows right after an accept
  `PAC_ASSERT_NXT(a_accept_quiet, clk, rst, start && !busy, !valid)
endmodule

bind pairwise_aabb_collision_engine_unit pac_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid),
  .last_hit(last_hit), .normal_axis(normal_axis)
);
